/* rtl/slp_pkg.sv */
// Shared types, token codes and keyword tables for the schema language lexer.
// Used by slp_front, slp_queue, slp_back and schema_language_lexer.
// No dependencies.
`default_nettype none

package slp_pkg;

   // Defaults for the top-level parameters
   localparam int MAX_NAME_DEF  = 32;
   localparam int LINE_BITS_DEF = 16;

   // Depth of the queue between front and back (power of two)
   localparam int QDEPTH = 4;

   // Token kinds
   localparam logic [4:0] K_NAMEBYTE = 5'd0;
   localparam logic [4:0] K_NUMBER   = 5'd1;
   localparam logic [4:0] K_IDENT    = 5'd2;
   localparam logic [4:0] K_LBRACE   = 5'd3;
   localparam logic [4:0] K_RBRACE   = 5'd4;
   localparam logic [4:0] K_EQUAL    = 5'd5;
   localparam logic [4:0] K_LBRACKET = 5'd6;
   localparam logic [4:0] K_RBRACKET = 5'd7;
   localparam logic [4:0] K_SEMI     = 5'd8;
   localparam logic [4:0] K_DOT      = 5'd9;
   localparam logic [4:0] K_COMMA    = 5'd10;
   localparam logic [4:0] K_KEY0     = 5'd11;
   localparam logic [4:0] K_ERR_BYTE = 5'd17;
   localparam logic [4:0] K_ERR_DOT  = 5'd18;
   localparam logic [4:0] K_ERR_LONG = 5'd19;
   localparam logic [4:0] K_DONE     = 5'd20;

   // Characters of interest
   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_NL    = 8'h0a;
   localparam logic [7:0] CH_CR    = 8'h0d;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_HASH  = 8'h23;
   localparam logic [7:0] CH_UNDER = 8'h5f;

   localparam int NUM_KW = 6;

   // Keyword spelling, one byte per position, zero past the end
   localparam logic [7:0] KW_TEXT [0:NUM_KW-1][0:6] = '{
      '{"m", "e", "s", "s", "a", "g", "e"},
      '{"i", "n", "t", "e", "g", "e", "r"},
      '{"s", "t", "r", "i", "n", "g", 8'h00},
      '{"r", "e", "a", "l", 8'h00, 8'h00, 8'h00},
      '{"b", "y", "t", "e", "s", 8'h00, 8'h00},
      '{"e", "x", "t", "e", "r", "n", 8'h00}
   };

   localparam logic [2:0] KW_LEN [0:NUM_KW-1] = '{3'd7, 3'd7, 3'd6, 3'd4, 3'd5, 3'd6};

   // Scanner modes
   typedef enum logic [2:0] {
      MODE_IDLE    = 3'd0,
      MODE_NAME    = 3'd1,
      MODE_NUM     = 3'd2,
      MODE_COMMENT = 3'd3,
      MODE_DOT     = 3'd4,
      MODE_STOP    = 3'd5
   } mode_type;

   // Byte classes
   typedef enum logic [2:0] {
      CLS_BAD   = 3'd0,
      CLS_NAME  = 3'd1,
      CLS_DIGIT = 3'd2,
      CLS_SKIP  = 3'd3,
      CLS_NL    = 3'd4,
      CLS_HASH  = 3'd5,
      CLS_PUNCT = 3'd6
   } class_type;

   typedef struct packed {
      class_type  cls;
      logic [4:0] punct;
   } byte_class_type;

   // One token without its line
   typedef struct packed {
      logic [4:0] kind;
      logic [7:0] nb;
      logic [5:0] len;
   } token_type;

   // All tokens caused by one text byte
   typedef struct packed {
      logic [15:0] line;
      token_type   tok0;
      token_type   tok1;
      logic        two;
   } entry_type;

   // Queue status seen by front and back
   typedef struct packed {
      logic full;
      logic not_empty;
   } queue_status_type;

   function automatic byte_class_type classify(input logic [7:0] b);
      byte_class_type r;
      r.cls   = CLS_BAD;
      r.punct = K_NAMEBYTE;
      priority if ((b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || b == CH_UNDER) begin
         r.cls = CLS_NAME;
      end else if (b >= "0" && b <= "9") begin
         r.cls = CLS_DIGIT;
      end else if (b == CH_SPACE || b == CH_TAB || b == CH_CR) begin
         r.cls = CLS_SKIP;
      end else if (b == CH_NL) begin
         r.cls = CLS_NL;
      end else if (b == CH_HASH) begin
         r.cls = CLS_HASH;
      end else if (b == "{") begin
         r.cls = CLS_PUNCT; r.punct = K_LBRACE;
      end else if (b == "}") begin
         r.cls = CLS_PUNCT; r.punct = K_RBRACE;
      end else if (b == "=") begin
         r.cls = CLS_PUNCT; r.punct = K_EQUAL;
      end else if (b == "[") begin
         r.cls = CLS_PUNCT; r.punct = K_LBRACKET;
      end else if (b == "]") begin
         r.cls = CLS_PUNCT; r.punct = K_RBRACKET;
      end else if (b == ";") begin
         r.cls = CLS_PUNCT; r.punct = K_SEMI;
      end else if (b == ".") begin
         r.cls = CLS_PUNCT; r.punct = K_DOT;
      end else if (b == ",") begin
         r.cls = CLS_PUNCT; r.punct = K_COMMA;
      end else begin
         r.cls = CLS_BAD;
      end
      return r;
   endfunction

endpackage

`default_nettype wire

/* rtl/schema_language_lexer.sv */
// Top level of the schema language lexer: front, token queue and back.
// Depends on slp_pkg, slp_front, slp_queue and slp_back.
//
// Usage: text bytes enter on the req_ stream, one byte per request; byte 0
// ends the text, gives a done token and returns the block to its reset
// state (line one). Tokens leave on the rsp_ stream: token kind on
// rsp_tuser, line, name byte and name length in rsp_tdata, and rsp_tlast
// set on the final token caused by one text byte. Bytes that cause no
// token (blanks, newlines, comments, bytes after an error) produce nothing.
// The entry is written into the queue when the byte is accepted, then moves
// from the queue into the output register that drives rsp_tvalid.
// Throughput: one byte per cycle while bytes cause at most one token each
// and rsp_tready stays high; the extra token of a byte that closes a run
// is absorbed by the four-entry queue between front and back.
// req_tready drops only when that queue is full, so a stalled receiver
// backs up into the queue and then stops the text stream; nothing is lost.
// Reset clears the scan state, the queue pointers and the output valid flag.
`default_nettype none

module schema_language_lexer #(
   parameter int MAX_NAME  = slp_pkg::MAX_NAME_DEF,
   parameter int LINE_BITS = slp_pkg::LINE_BITS_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] text_byte
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [31:0]      rsp_tdata,   // [15:0] line_number, [23:16] name_byte,
                                         // [29:24] name_length, [31:30] zero
   output logic [4:0]       rsp_tuser,   // [4:0] token_kind
   output logic             rsp_tlast    // last_of_run
);

   slp_pkg::queue_status_type q_status;
   slp_pkg::entry_type        push_entry, head_entry;
   slp_pkg::token_type        out_tok;
   logic                      push, pop;
   logic [15:0]               out_line;

   slp_front #(
      .MAX_NAME  (MAX_NAME),
      .LINE_BITS (LINE_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_byte    (req_tdata),
      .in_ready   (req_tready),
      .q_status   (q_status),
      .push       (push),
      .push_entry (push_entry)
   );

   slp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head_entry (head_entry),
      .status     (q_status)
   );

   slp_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_entry (head_entry),
      .q_status   (q_status),
      .pop        (pop),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_tok    (out_tok),
      .out_line   (out_line),
      .out_last   (rsp_tlast)
   );

   // pack result fields
   assign rsp_tdata = {2'b00, out_tok.len, out_tok.nb, out_line};
   assign rsp_tuser = out_tok.kind;

endmodule

`default_nettype wire

/* rtl/slp_front.sv */
// Front part of the lexer: classifies each text byte, keeps the scan state
// and builds the token entry for the queue. Depends on slp_pkg.
`default_nettype none

module slp_front #(
   parameter int MAX_NAME  = slp_pkg::MAX_NAME_DEF,
   parameter int LINE_BITS = slp_pkg::LINE_BITS_DEF
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      in_valid,
   input  wire logic [7:0]                in_byte,
   output logic                           in_ready,
   input  wire slp_pkg::queue_status_type q_status,
   output logic                           push,
   output slp_pkg::entry_type             push_entry
);

   localparam int NCW = $clog2(MAX_NAME + 1);

   slp_pkg::mode_type      mode_ff, mode_in;
   logic [LINE_BITS-1:0]   line_ff, line_in, line_next;
   logic [5:0]             cand_ff, cand_in;
   logic [NCW-1:0]         count_ff, count_in;

   slp_pkg::byte_class_type bc;
   logic                    accept;
   logic                    is_zero;
   logic [5:0]              cand_fresh, cand_narrow;
   logic [4:0]              close_kind;
   logic                    cont;
   logic [LINE_BITS+15:0]   line_wide;

   // idle-mode action, shared by the idle path and the path after a close
   logic                    idle_vld;
   slp_pkg::token_type      idle_tok;
   logic [5:0]              idle_cand;
   logic [NCW-1:0]          idle_count;
   logic [LINE_BITS-1:0]    idle_line;
   slp_pkg::mode_type       idle_mode;

   slp_pkg::token_type      tok0, tok1;
   logic                    two, any;

   assign in_ready = !q_status.full;
   assign accept   = in_valid && in_ready;
   assign bc       = slp_pkg::classify(in_byte);
   assign is_zero  = (in_byte == slp_pkg::CH_NUL);
   assign cont     = (bc.cls == slp_pkg::CLS_DIGIT) ||
                     (mode_ff == slp_pkg::MODE_NAME && bc.cls == slp_pkg::CLS_NAME);

   // saturating line count
   assign line_next = (line_ff == '1) ? line_ff : line_ff + LINE_BITS'(1);

   // keyword candidate narrowing, from scratch and from the current mask
   always_comb begin
      cand_fresh  = '0;
      cand_narrow = '0;
      for (int i = 0; i < slp_pkg::NUM_KW; i++) begin
         cand_fresh[i]  = (slp_pkg::KW_TEXT[i][0] == in_byte);
         cand_narrow[i] = cand_ff[i] && (count_ff < NCW'(7)) &&
                          (slp_pkg::KW_TEXT[i][count_ff[2:0]] == in_byte);
      end
   end

   // kind of the token that closes a run
   always_comb begin
      close_kind = slp_pkg::K_IDENT;
      if (mode_ff == slp_pkg::MODE_NUM) begin
         close_kind = slp_pkg::K_NUMBER;
      end else begin
         for (int i = slp_pkg::NUM_KW - 1; i >= 0; i--) begin
            if (cand_ff[i] && NCW'(slp_pkg::KW_LEN[i]) == count_ff) begin
               close_kind = slp_pkg::K_KEY0 + 5'(i);
            end
         end
      end
   end

   // action of a byte seen between tokens
   always_comb begin
      idle_vld   = 1'b0;
      idle_tok   = '0;
      idle_cand  = 6'h3f;
      idle_count = '0;
      idle_line  = line_ff;
      idle_mode  = slp_pkg::MODE_IDLE;
      if (is_zero) begin
         idle_vld      = 1'b1;
         idle_tok.kind = slp_pkg::K_DONE;
         idle_line     = LINE_BITS'(1);
      end else begin
         unique case (bc.cls)
            slp_pkg::CLS_NAME: begin
               idle_vld   = 1'b1;
               idle_tok.nb = in_byte;
               idle_cand  = cand_fresh;
               idle_count = NCW'(1);
               idle_mode  = slp_pkg::MODE_NAME;
            end
            slp_pkg::CLS_DIGIT: begin
               idle_vld   = 1'b1;
               idle_tok.nb = in_byte;
               idle_cand  = '0;
               idle_count = NCW'(1);
               idle_mode  = slp_pkg::MODE_NUM;
            end
            slp_pkg::CLS_SKIP: begin
            end
            slp_pkg::CLS_NL: begin
               idle_line = line_next;
            end
            slp_pkg::CLS_HASH: begin
               idle_mode = slp_pkg::MODE_COMMENT;
            end
            slp_pkg::CLS_PUNCT: begin
               idle_vld      = 1'b1;
               idle_tok.kind = bc.punct;
               if (bc.punct == slp_pkg::K_DOT) begin
                  idle_mode = slp_pkg::MODE_DOT;
               end
            end
            default: begin
               idle_vld      = 1'b1;
               idle_tok.kind = slp_pkg::K_ERR_BYTE;
               idle_mode     = slp_pkg::MODE_STOP;
            end
         endcase
      end
   end

   // next scan mode
   always_comb begin
      mode_in = mode_ff;
      unique case (mode_ff)
         slp_pkg::MODE_STOP: begin
            if (is_zero) mode_in = slp_pkg::MODE_IDLE;
         end
         slp_pkg::MODE_COMMENT: begin
            if (is_zero || in_byte == slp_pkg::CH_NL) mode_in = slp_pkg::MODE_IDLE;
         end
         slp_pkg::MODE_DOT: begin
            if (bc.cls == slp_pkg::CLS_NAME) mode_in = slp_pkg::MODE_NAME;
            else if (is_zero) mode_in = slp_pkg::MODE_IDLE;
            else mode_in = slp_pkg::MODE_STOP;
         end
         slp_pkg::MODE_NAME, slp_pkg::MODE_NUM: begin
            if (cont) begin
               if (count_ff >= NCW'(MAX_NAME)) mode_in = slp_pkg::MODE_STOP;
            end else begin
               mode_in = idle_mode;
            end
         end
         slp_pkg::MODE_IDLE: begin
            mode_in = idle_mode;
         end
         default: begin
            mode_in = slp_pkg::MODE_IDLE;
         end
      endcase
   end

   // tokens and data state
   always_comb begin
      tok0     = '0;
      tok1     = '0;
      two      = 1'b0;
      any      = 1'b0;
      cand_in  = cand_ff;
      count_in = count_ff;
      line_in  = line_ff;
      unique case (mode_ff)
         slp_pkg::MODE_STOP: begin
            if (is_zero) begin
               any       = 1'b1;
               tok0.kind = slp_pkg::K_DONE;
               line_in   = LINE_BITS'(1);
               cand_in   = 6'h3f;
               count_in  = '0;
            end
         end
         slp_pkg::MODE_COMMENT: begin
            if (is_zero) begin
               any       = 1'b1;
               tok0.kind = slp_pkg::K_DONE;
               line_in   = LINE_BITS'(1);
               cand_in   = 6'h3f;
               count_in  = '0;
            end else if (in_byte == slp_pkg::CH_NL) begin
               line_in = line_next;
            end
         end
         slp_pkg::MODE_DOT: begin
            any = 1'b1;
            if (bc.cls == slp_pkg::CLS_NAME) begin
               tok0.nb  = in_byte;
               cand_in  = cand_fresh;
               count_in = NCW'(1);
            end else begin
               tok0.kind = slp_pkg::K_ERR_DOT;
               if (is_zero) begin
                  two       = 1'b1;
                  tok1.kind = slp_pkg::K_DONE;
                  line_in   = LINE_BITS'(1);
                  cand_in   = 6'h3f;
                  count_in  = '0;
               end
            end
         end
         slp_pkg::MODE_NAME, slp_pkg::MODE_NUM: begin
            any = 1'b1;
            if (cont) begin
               if (count_ff >= NCW'(MAX_NAME)) begin
                  tok0.kind = slp_pkg::K_ERR_LONG;
               end else begin
                  tok0.nb  = in_byte;
                  count_in = count_ff + NCW'(1);
                  if (mode_ff == slp_pkg::MODE_NAME) cand_in = cand_narrow;
               end
            end else begin
               tok0.kind = close_kind;
               tok0.len  = 6'(count_ff);
               two       = idle_vld;
               tok1      = idle_tok;
               cand_in   = idle_cand;
               count_in  = idle_count;
               line_in   = idle_line;
            end
         end
         slp_pkg::MODE_IDLE: begin
            any      = idle_vld;
            tok0     = idle_tok;
            cand_in  = idle_cand;
            count_in = idle_count;
            line_in  = idle_line;
         end
         default: begin
         end
      endcase
   end

   // queue entry; line is the low 16 bits of the count
   assign line_wide       = {16'b0, line_ff};
   assign push            = accept && any;
   assign push_entry.line = line_wide[15:0];
   assign push_entry.tok0 = tok0;
   assign push_entry.tok1 = tok1;
   assign push_entry.two  = two;

   // scan state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= slp_pkg::MODE_IDLE;
         line_ff  <= LINE_BITS'(1);
         cand_ff  <= 6'h3f;
         count_ff <= '0;
      end else if (accept) begin
         mode_ff  <= mode_in;
         line_ff  <= line_in;
         cand_ff  <= cand_in;
         count_ff <= count_in;
      end
   end

endmodule

`default_nettype wire

/* rtl/slp_queue.sv */
// Short queue of token entries between the lexer front and back.
// Depends on slp_pkg.
`default_nettype none

module slp_queue (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push,
   input  wire slp_pkg::entry_type  push_entry,
   input  wire logic                pop,
   output slp_pkg::entry_type       head_entry,
   output slp_pkg::queue_status_type status
);

   localparam int QAW = $clog2(slp_pkg::QDEPTH);

   slp_pkg::entry_type store_ff [slp_pkg::QDEPTH];
   logic [QAW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [QAW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [QAW:0]       fill_ff, fill_in;

   assign status.full      = (fill_ff == (QAW+1)'(slp_pkg::QDEPTH));
   assign status.not_empty = (fill_ff != '0);
   assign head_entry       = store_ff[rd_ptr_ff];

   // pointer and fill update
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QAW'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + QAW'(1) : rd_ptr_ff;
      fill_in   = fill_ff;
      unique case ({push, pop})
         2'b10:   fill_in = fill_ff + (QAW+1)'(1);
         2'b01:   fill_in = fill_ff - (QAW+1)'(1);
         default: fill_in = fill_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

`default_nettype wire

/* rtl/slp_back.sv */
// Back part of the lexer: splits each queue entry into one or two tokens
// and holds them in the output register. Depends on slp_pkg.
`default_nettype none

module slp_back (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire slp_pkg::entry_type        head_entry,
   input  wire slp_pkg::queue_status_type q_status,
   output logic                           pop,
   output logic                           out_valid,
   input  wire logic                      out_ready,
   output slp_pkg::token_type             out_tok,
   output logic [15:0]                    out_line,
   output logic                           out_last
);

   logic               valid_ff, valid_in;
   logic               second_ff, second_in;
   slp_pkg::token_type tok_ff, tok_in;
   logic [15:0]        line_ff, line_in;
   logic               last_ff, last_in;
   logic               load;

   assign load = q_status.not_empty && (!valid_ff || out_ready);

   // pick the pending half of the head entry
   always_comb begin
      valid_in  = valid_ff && !out_ready;
      second_in = second_ff;
      tok_in    = tok_ff;
      line_in   = line_ff;
      last_in   = last_ff;
      pop       = 1'b0;
      if (load) begin
         valid_in = 1'b1;
         line_in  = head_entry.line;
         if (second_ff) begin
            tok_in    = head_entry.tok1;
            last_in   = 1'b1;
            pop       = 1'b1;
            second_in = 1'b0;
         end else begin
            tok_in    = head_entry.tok0;
            last_in   = !head_entry.two;
            pop       = !head_entry.two;
            second_in = head_entry.two;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= 1'b0;
         second_ff <= 1'b0;
      end else begin
         valid_ff  <= valid_in;
         second_ff <= second_in;
      end
   end

   // output payload
   always_ff @(posedge clock) begin
      tok_ff  <= tok_in;
      line_ff <= line_in;
      last_ff <= last_in;
   end

   assign out_valid = valid_ff;
   assign out_tok   = tok_ff;
   assign out_line  = line_ff;
   assign out_last  = last_ff;

endmodule

`default_nettype wire
